/* design/hslrgb_pkg.sv */
// Package for the HSL to RGB converter: fixed-point widths, hue thresholds,
// pipeline payload types and the output saturation function.
// No dependencies.
package hslrgb_pkg;

    localparam int FRAC_BITS = 16;

    localparam int HW  = FRAC_BITS;
    localparam int VW  = FRAC_BITS + 1;
    localparam int PRW = 2 * FRAC_BITS + 2;
    localparam int PW  = FRAC_BITS + 4;
    localparam int DW  = FRAC_BITS + 7;
    localparam int FW  = FRAC_BITS - 2;
    localparam int MW  = DW + FW + 1;
    localparam int SW  = FRAC_BITS + 7;

    localparam int ONE_I   = 1 << FRAC_BITS;
    localparam int HALF_I  = ONE_I / 2;
    localparam int THIRD_I = ONE_I / 3;
    localparam int SIXTH_I = (ONE_I + 5) / 6;
    localparam int TWO3_I  = (2 * ONE_I + 2) / 3;

    localparam logic [VW-1:0] ONE_V   = VW'(ONE_I);
    localparam logic [VW-1:0] HALF_V  = VW'(HALF_I);
    localparam logic [HW-1:0] THIRD_V = HW'(THIRD_I);
    localparam logic [HW-1:0] SIXTH_V = HW'(SIXTH_I);
    localparam logic [HW-1:0] HUE_HALF_V = HW'(HALF_I);
    localparam logic [HW-1:0] TWO3_V  = HW'(TWO3_I);

    typedef enum logic [1:0] {
        REG_RISE = 2'd0,
        REG_HIGH = 2'd1,
        REG_FALL = 2'd2,
        REG_LOW  = 2'd3
    } region_t;

    typedef struct packed {
        logic signed [PW-1:0] p;
        logic signed [PW-1:0] q;
        logic signed [DW-1:0] d6;
    } levels_t;

    typedef struct packed {
        region_t         region;
        logic [FW-1:0]   factor;
    } chan_sel_t;

    function automatic logic [VW-1:0] sat_unit(input logic signed [SW-1:0] v);
        logic [VW-1:0] r;
        if (v[SW-1]) begin
            r = '0;
        end else if (v > $signed(SW'(ONE_I))) begin
            r = ONE_V;
        end else begin
            r = v[VW-1:0];
        end
        return r;
    endfunction

endpackage

/* design/hsl_to_rgb_converter.sv */
// Top level of the HSL to RGB converter: front stages plus three channel units.
// Depends on hslrgb_pkg, hslrgb_front and hslrgb_chan.
//
//   channel   handshake        payload
//   request   start / busy     hue, saturation, lightness
//   result    done (strobe)    red, green, blue
//
// A request is taken in any cycle; busy is always low.
// The pipeline has two front stages and two channel stages, its
// length set by the lightness-saturation multiply and the ramp multiply.
// Reset clears only the valid bits along the pipeline.
// The receiver cannot stall, so results leave as they are produced.
module hsl_to_rgb_converter (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [hslrgb_pkg::HW-1:0]   hue,
    input  logic [hslrgb_pkg::VW-1:0]   saturation,
    input  logic [hslrgb_pkg::VW-1:0]   lightness,
    output logic                        done,
    output logic [hslrgb_pkg::VW-1:0]   red,
    output logic [hslrgb_pkg::VW-1:0]   green,
    output logic [hslrgb_pkg::VW-1:0]   blue
);

    logic                    accept;
    logic                    front_valid;
    hslrgb_pkg::levels_t     levels;
    hslrgb_pkg::chan_sel_t   sel_r;
    hslrgb_pkg::chan_sel_t   sel_g;
    hslrgb_pkg::chan_sel_t   sel_b;
    logic                    valid_r;
    logic                    valid_g;
    logic                    valid_b;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    hslrgb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .hue       (hue),
        .saturation(saturation),
        .lightness (lightness),
        .out_valid (front_valid),
        .levels    (levels),
        .sel_r     (sel_r),
        .sel_g     (sel_g),
        .sel_b     (sel_b)
    );

    hslrgb_chan u_red (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (front_valid),
        .levels   (levels),
        .sel      (sel_r),
        .out_valid(valid_r),
        .value    (red)
    );

    hslrgb_chan u_green (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (front_valid),
        .levels   (levels),
        .sel      (sel_g),
        .out_valid(valid_g),
        .value    (green)
    );

    hslrgb_chan u_blue (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (front_valid),
        .levels   (levels),
        .sel      (sel_b),
        .out_valid(valid_b),
        .value    (blue)
    );

    assign done = valid_r;

    a_lanes_agree: assert property (@(posedge clk) disable iff (!rst_n)
        valid_r == valid_g && valid_g == valid_b)
        else $error("channel valid bits disagree");

    a_done_follows_front: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(front_valid, 2))
        else $error("result without a request two stages earlier");

    a_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (red <= hslrgb_pkg::ONE_V && green <= hslrgb_pkg::ONE_V
                  && blue <= hslrgb_pkg::ONE_V))
        else $error("channel above full scale");

endmodule

/* design/hslrgb_front.sv */
// Front two pipeline stages: lightness times saturation and hue offsets,
// then the q and p levels, the ramp slope and each channel's hue region.
// Depends on hslrgb_pkg.
module hslrgb_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic [hslrgb_pkg::HW-1:0]        hue,
    input  logic [hslrgb_pkg::VW-1:0]        saturation,
    input  logic [hslrgb_pkg::VW-1:0]        lightness,
    output logic                             out_valid,
    output hslrgb_pkg::levels_t              levels,
    output hslrgb_pkg::chan_sel_t            sel_r,
    output hslrgb_pkg::chan_sel_t            sel_g,
    output hslrgb_pkg::chan_sel_t            sel_b
);

    logic                        v1_reg;
    logic [hslrgb_pkg::VW-1:0]   l1_reg;
    logic [hslrgb_pkg::VW-1:0]   s1_reg;
    logic [hslrgb_pkg::PRW-1:0]  prod1_reg;
    logic [hslrgb_pkg::HW-1:0]   tr1_reg;
    logic [hslrgb_pkg::HW-1:0]   tg1_reg;
    logic [hslrgb_pkg::HW-1:0]   tb1_reg;

    logic                        v2_reg;
    hslrgb_pkg::levels_t         levels_reg;
    hslrgb_pkg::levels_t         levels_next;
    hslrgb_pkg::chan_sel_t       sel_r_reg;
    hslrgb_pkg::chan_sel_t       sel_g_reg;
    hslrgb_pkg::chan_sel_t       sel_b_reg;

    logic signed [hslrgb_pkg::PW-1:0] l_ext;
    logic signed [hslrgb_pkg::PW-1:0] s_ext;
    logic signed [hslrgb_pkg::PW-1:0] ls_ext;
    logic signed [hslrgb_pkg::PW-1:0] q_w;
    logic signed [hslrgb_pkg::PW-1:0] p_w;
    logic signed [hslrgb_pkg::DW-1:0] d_w;

    function automatic hslrgb_pkg::chan_sel_t classify(input logic [hslrgb_pkg::HW-1:0] t);
        hslrgb_pkg::chan_sel_t r;
        logic [hslrgb_pkg::HW-1:0] down;
        down = hslrgb_pkg::TWO3_V - t;
        if (t < hslrgb_pkg::SIXTH_V) begin
            r.region = hslrgb_pkg::REG_RISE;
            r.factor = t[hslrgb_pkg::FW-1:0];
        end else if (t < hslrgb_pkg::HUE_HALF_V) begin
            r.region = hslrgb_pkg::REG_HIGH;
            r.factor = '0;
        end else if (t < hslrgb_pkg::TWO3_V) begin
            r.region = hslrgb_pkg::REG_FALL;
            r.factor = down[hslrgb_pkg::FW-1:0];
        end else begin
            r.region = hslrgb_pkg::REG_LOW;
            r.factor = '0;
        end
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk) begin
        l1_reg    <= lightness;
        s1_reg    <= saturation;
        prod1_reg <= hslrgb_pkg::PRW'(lightness) * hslrgb_pkg::PRW'(saturation);
        tr1_reg   <= hue + hslrgb_pkg::THIRD_V;
        tg1_reg   <= hue;
        tb1_reg   <= hue - hslrgb_pkg::THIRD_V;
    end

    always_comb begin
        l_ext  = $signed({{(hslrgb_pkg::PW - hslrgb_pkg::VW){1'b0}}, l1_reg});
        s_ext  = $signed({{(hslrgb_pkg::PW - hslrgb_pkg::VW){1'b0}}, s1_reg});
        ls_ext = $signed({2'b00, prod1_reg[hslrgb_pkg::PRW-1:hslrgb_pkg::FRAC_BITS]});
        if (l1_reg < hslrgb_pkg::HALF_V) begin
            q_w = l_ext + ls_ext;
        end else begin
            q_w = l_ext + s_ext - ls_ext;
        end
        p_w = (l_ext <<< 1) - q_w;
        d_w = $signed({{(hslrgb_pkg::DW - hslrgb_pkg::PW){q_w[hslrgb_pkg::PW-1]}}, q_w})
            - $signed({{(hslrgb_pkg::DW - hslrgb_pkg::PW){p_w[hslrgb_pkg::PW-1]}}, p_w});
        levels_next.p  = p_w;
        levels_next.q  = q_w;
        levels_next.d6 = (d_w <<< 2) + (d_w <<< 1);
    end

    always_ff @(posedge clk) begin
        levels_reg <= levels_next;
        sel_r_reg  <= classify(tr1_reg);
        sel_g_reg  <= classify(tg1_reg);
        sel_b_reg  <= classify(tb1_reg);
    end

    assign out_valid = v2_reg;
    assign levels    = levels_reg;
    assign sel_r     = sel_r_reg;
    assign sel_g     = sel_g_reg;
    assign sel_b     = sel_b_reg;

endmodule

/* design/hslrgb_chan.sv */
// Back two pipeline stages for one color channel: ramp multiply, then
// level selection, floor shift and saturation to 0..1.
// Depends on hslrgb_pkg.
module hslrgb_chan (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  hslrgb_pkg::levels_t         levels,
    input  hslrgb_pkg::chan_sel_t       sel,
    output logic                        out_valid,
    output logic [hslrgb_pkg::VW-1:0]   value
);

    logic                               v3_reg;
    logic signed [hslrgb_pkg::MW-1:0]   prod_reg;
    logic signed [hslrgb_pkg::PW-1:0]   p_reg;
    logic signed [hslrgb_pkg::PW-1:0]   q_reg;
    hslrgb_pkg::region_t                region_reg;

    logic                               v4_reg;
    logic [hslrgb_pkg::VW-1:0]          value_reg;
    logic [hslrgb_pkg::VW-1:0]          value_next;

    logic signed [hslrgb_pkg::SW-1:0]   ramp_w;
    logic signed [hslrgb_pkg::SW-1:0]   p_w;
    logic signed [hslrgb_pkg::SW-1:0]   q_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= in_valid;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= hslrgb_pkg::MW'(levels.d6)
                      * hslrgb_pkg::MW'($signed({1'b0, sel.factor}));
        p_reg      <= levels.p;
        q_reg      <= levels.q;
        region_reg <= sel.region;
    end

    always_comb
    begin
        p_w    = $signed({{(hslrgb_pkg::SW - hslrgb_pkg::PW){p_reg[hslrgb_pkg::PW-1]}}, p_reg});
        q_w    = $signed({{(hslrgb_pkg::SW - hslrgb_pkg::PW){q_reg[hslrgb_pkg::PW-1]}}, q_reg});
        ramp_w = p_w + $signed({prod_reg[hslrgb_pkg::MW-1],
                                prod_reg[hslrgb_pkg::MW-1:hslrgb_pkg::FRAC_BITS]});
        unique case (region_reg)
            hslrgb_pkg::REG_RISE: value_next = hslrgb_pkg::sat_unit(ramp_w);
            hslrgb_pkg::REG_FALL: value_next = hslrgb_pkg::sat_unit(ramp_w);
            hslrgb_pkg::REG_HIGH: value_next = hslrgb_pkg::sat_unit(q_w);
            hslrgb_pkg::REG_LOW:  value_next = hslrgb_pkg::sat_unit(p_w);
            default:              value_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign out_valid = v4_reg;
    assign value     = value_reg;

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// Testbench for hsl_to_rgb_converter: directed hue, range and zero-saturation
// pixels, then random pixels with random request gaps, checked against a local model.
// Depends on hslrgb_pkg and the hsl_to_rgb_converter design.
module tb_top;
    import hslrgb_pkg::*;

    typedef struct {
        logic [VW-1:0] red;
        logic [VW-1:0] green;
        logic [VW-1:0] blue;
    } rgb_t;

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    logic [HW-1:0] hue;
    logic [VW-1:0] saturation;
    logic [VW-1:0] lightness;
    logic          done;
    logic [VW-1:0] red;
    logic [VW-1:0] green;
    logic [VW-1:0] blue;

    rgb_t pending_rgb[$];
    int   mismatch_count;

    hsl_to_rgb_converter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .hue        (hue),
        .saturation (saturation),
        .lightness  (lightness),
        .done       (done),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [VW-1:0] clamp_unit(input longint v);
        logic [VW-1:0] r;
        if (v < 0)
            r = '0;
        else if (v > ONE_I)
            r = VW'(ONE_I);
        else
            r = v[VW-1:0];
        return r;
    endfunction

    function automatic longint ramp_level(input longint p, input longint q, input longint t);
        longint v;
        if (t < SIXTH_I)
            v = p + ((6 * (q - p) * t) >>> FRAC_BITS);
        else if (t < HALF_I)
            v = q;
        else if (t < TWO3_I)
            v = p + ((6 * (q - p) * (TWO3_I - t)) >>> FRAC_BITS);
        else
            v = p;
        return v;
    endfunction

    function automatic rgb_t predict_rgb(input logic [HW-1:0] h, input logic [VW-1:0] s,
                                         input logic [VW-1:0] l);
        rgb_t          c;
        longint        sv;
        longint        lv;
        longint        ls;
        longint        q;
        longint        p;
        logic [HW-1:0] t_red;
        logic [HW-1:0] t_blue;
        sv = s;
        lv = l;
        if (s == '0)
        begin
            c.red   = clamp_unit(lv);
            c.green = c.red;
            c.blue  = c.red;
        end
        else
        begin
            ls = (lv * sv) >>> FRAC_BITS;
            if (lv < HALF_I)
                q = lv + ls;
            else
                q = lv + sv - ls;
            p = 2 * lv - q;
            t_red  = h + HW'(THIRD_I);
            t_blue = h - HW'(THIRD_I);
            c.red   = clamp_unit(ramp_level(p, q, longint'(t_red)));
            c.green = clamp_unit(ramp_level(p, q, longint'(h)));
            c.blue  = clamp_unit(ramp_level(p, q, longint'(t_blue)));
        end
        return c;
    endfunction

    // Called at a rising edge; returns at the edge where the request is taken.
    task automatic send_pixel(input logic [HW-1:0] h, input logic [VW-1:0] s,
                              input logic [VW-1:0] l);
        start      <= 1'b1;
        hue        <= h;
        saturation <= s;
        lightness  <= l;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
        pending_rgb.push_back(predict_rgb(h, s, l));
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic int random_gap();
        int r;
        int g;
        r = $urandom_range(0, 99);
        if (r < 60)
            g = 0;
        else if (r < 92)
            g = $urandom_range(1, 3);
        else
            g = $urandom_range(8, 40);
        return g;
    endfunction

    function automatic logic [VW-1:0] random_level();
        int            r;
        logic [VW-1:0] v;
        r = $urandom_range(0, 99);
        if (r < 6)
            v = '0;
        else if (r < 10)
            v = VW'(ONE_I);
        else if (r < 13)
            v = VW'(HALF_I);
        else if (r < 28)
            v = VW'($urandom_range(0, (1 << VW) - 1));
        else
            v = VW'($urandom_range(0, ONE_I));
        return v;
    endfunction

    task automatic send_random_pixel(input int gap);
        send_pixel(HW'($urandom), random_level(), random_level());
        idle_cycles(gap);
    endtask

    task automatic test_zero_saturation();
        send_pixel('0, '0, '0);
        send_pixel(HW'(12345), '0, VW'(ONE_I));
        send_pixel('1, '0, '1);
        send_pixel(HW'(40000), '0, VW'(HALF_I));
        idle_cycles(2);
    endtask

    task automatic test_hue_regions();
        int boundaries[11] = '{0, SIXTH_I - 1, SIXTH_I, THIRD_I - 1, THIRD_I, HALF_I - 1,
                               HALF_I, TWO3_I - 1, TWO3_I, ONE_I - THIRD_I, ONE_I - 1};
        foreach (boundaries[i])
            send_pixel(HW'(boundaries[i]), VW'(ONE_I), VW'(HALF_I));
        idle_cycles(1);
    endtask

    task automatic test_range_extremes();
        send_pixel(HW'(5000), VW'(ONE_I), VW'(ONE_I));
        send_pixel(HW'(60000), '1, '1);
        send_pixel(HW'(30000), VW'(1), VW'(1));
        send_pixel(HW'(10000), '1, '0);
        send_pixel(HW'(50000), VW'(ONE_I), '0);
        send_pixel(HW'(20000), VW'(100000), VW'(HALF_I - 1));
        send_pixel(HW'(45000), VW'(ONE_I - 1), VW'(HALF_I));
        send_pixel(HW'(2000), VW'(98304), VW'(98304));
        idle_cycles(3);
    endtask

    // Bursts of back-to-back requests are mixed at random with stretches of random gaps.
    task automatic test_random_pixels(input int count);
        bit no_gaps;
        for (int i = 0; i < count; i++)
        begin
            if (i % 50 == 0)
                no_gaps = ($urandom_range(0, 2) == 0);
            send_random_pixel(no_gaps ? 0 : random_gap());
        end
    endtask

    task automatic test_drain_pause();
        repeat (12) send_random_pixel(0);
        start <= 1'b0;
        while (pending_rgb.size() != 0)
            @(posedge clk);
        repeat (12) send_random_pixel(random_gap());
    endtask

    always @(posedge clk)
    begin : check_rgb
        rgb_t want;
        if (rst_n && done)
        begin
            if (pending_rgb.size() == 0)
            begin
                $error("result with no request waiting: red=%0d green=%0d blue=%0d",
                       red, green, blue);
                mismatch_count++;
            end
            else
            begin
                want = pending_rgb.pop_front();
                if (red !== want.red)
                begin
                    $error("red: expected %0d, actual %0d", want.red, red);
                    mismatch_count++;
                end
                if (green !== want.green)
                begin
                    $error("green: expected %0d, actual %0d", want.green, green);
                    mismatch_count++;
                end
                if (blue !== want.blue)
                begin
                    $error("blue: expected %0d, actual %0d", want.blue, blue);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        mismatch_count = 0;
        rst_n      = 1'b0;
        start      = 1'b0;
        hue        = '0;
        saturation = '0;
        lightness  = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_zero_saturation();
        test_hue_regions();
        test_range_extremes();
        test_random_pixels(550);
        test_drain_pause();
        test_random_pixels(550);
        start <= 1'b0;
        while (pending_rgb.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && pending_rgb.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* files.f */
design/hslrgb_pkg.sv
design/hslrgb_front.sv
design/hslrgb_chan.sv
design/hsl_to_rgb_converter.sv
bench/tb_top.sv
